### design/rtbk_pkg.sv
// Shared types, constants and arithmetic helpers for the rate/torque/bias filter.
`default_nettype none

package rtbk_pkg;

  localparam int DataWidth = 32;
  localparam int CoefWidth = 32;
  localparam int DecayWidth = 25;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 32;
  localparam int MulInWidth = 33;
  localparam int AccWidth = 56;
  localparam int ProdWidth = AccWidth + 16;
  localparam int DecaySWidth = DecayWidth + 1;

  localparam logic signed [DecaySWidth-1:0] OneQ24 = DecaySWidth'(1 << 24);

  typedef enum logic {
    OpStep   = 1'b0,
    OpReinit = 1'b1
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegDecay      = 3'd0,
    RegRateTorque = 3'd1,
    RegRateBias   = 3'd2,
    RegGainRate   = 3'd3,
    RegGainTorque = 3'd4,
    RegGainBias   = 3'd5,
    RegInitBias   = 3'd6
  } cfg_reg_e;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [AccWidth-1:0] acc_t;

  // Q16.16 times Q8.24, floored to Q16.24.
  function automatic acc_t mul_term(input logic signed [MulInWidth-1:0] val,
                                    input logic signed [MulInWidth-1:0] coef);
    logic signed [ProdWidth-1:0] p;
    p = val * coef;
    return p[ProdWidth-1:16];
  endfunction

  // Round Q16.24 to Q16.16 and saturate to the data width.
  function automatic data_t finish(input acc_t acc);
    acc_t r;
    r = (acc + AccWidth'(128)) >>> 8;
    if (r[AccWidth-1:DataWidth-1] == '0 || r[AccWidth-1:DataWidth-1] == '1) begin
      return r[DataWidth-1:0];
    end else if (r[AccWidth-1]) begin
      return {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      return {1'b0, {(DataWidth-1){1'b1}}};
    end
  endfunction

  function automatic acc_t widen(input data_t v);
    return {{(AccWidth-DataWidth){v[DataWidth-1]}}, v};
  endfunction

endpackage

`default_nettype wire

### design/rtbk_if.sv
// Handshake channel interfaces for the filter: step input, state result, register write.
`default_nettype none

interface rtbk_in_if;
  logic                                      valid;
  logic                                      ready;
  rtbk_pkg::op_e                             operation;
  logic signed [rtbk_pkg::DataWidth-1:0]     control;
  logic signed [rtbk_pkg::DataWidth-1:0]     gyro;

  modport source (output valid, output operation, output control, output gyro, input ready);
  modport sink (input valid, input operation, input control, input gyro, output ready);
endinterface

interface rtbk_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [rtbk_pkg::DataWidth-1:0]     rate;
  logic signed [rtbk_pkg::DataWidth-1:0]     torque;
  logic signed [rtbk_pkg::DataWidth-1:0]     bias;

  modport source (output valid, output rate, output torque, output bias, input ready);
  modport sink (input valid, input rate, input torque, input bias, output ready);
endinterface

interface rtbk_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [rtbk_pkg::CfgIdxWidth-1:0]          index;
  logic [rtbk_pkg::CfgDataWidth-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/rate_torque_bias_kalman_step.sv
// Top level: one axis of a fixed-gain rate/torque/bias Kalman filter step.
//
//   port   dir  word                          takes
//   in_i   in   operation, control, gyro      step or reinit of the state
//   out_o  out  rate, torque, bias            state after each input word
//   cfg_i  in   index, data                   coefficient and initial bias writes
//
// One word per cycle unless out_o stalls: the input register holds a word, then the
// nine multipliers and the three sums update the state, which is the result register.
// Result valid rises when the word in the input register updates the state register.
// Reset clears the state and loads the default coefficients; cfg_i is always ready.
// A stalled result holds the state; the input register still takes one more word.
`default_nettype none

module rate_torque_bias_kalman_step (
  input  wire             clk_i,
  input  wire             rst_ni,
  rtbk_in_if.sink         in_i,
  rtbk_out_if.source      out_o,
  rtbk_cfg_if.sink        cfg_i
);

  localparam int Mw = rtbk_pkg::MulInWidth;
  localparam int Sw = rtbk_pkg::DecaySWidth;

  logic [rtbk_pkg::DecayWidth-1:0]      decay_q;
  logic signed [rtbk_pkg::CoefWidth-1:0] ad12_q, ad13_q, k_rate_q, k_torque_q, k_bias_q;
  rtbk_pkg::data_t                      reload_bias_q;

  logic            in_vld_q, in_vld_d;
  rtbk_pkg::op_e   op_q;
  rtbk_pkg::data_t ctrl_q, gyro_q;

  logic            out_vld_q, out_vld_d;
  rtbk_pkg::data_t rate_q, torque_q, bias_q;
  rtbk_pkg::data_t rate_d, torque_d, bias_d;

  logic fire;
  logic in_take;

  logic signed [Mw-1:0] err;
  logic signed [Sw-1:0] ets, ets_m1, one_m_ets;
  rtbk_pkg::acc_t acc_rate, acc_torque, acc_bias;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q       <= rtbk_pkg::DecayWidth'(1 << 24);
      ad12_q        <= '0;
      ad13_q        <= '0;
      k_rate_q      <= 32'sd736560;
      k_torque_q    <= 32'sd3355;
      k_bias_q      <= -32'sd1678;
      reload_bias_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rtbk_pkg::RegDecay:      decay_q       <= cfg_i.data[rtbk_pkg::DecayWidth-1:0];
        rtbk_pkg::RegRateTorque: ad12_q        <= cfg_i.data;
        rtbk_pkg::RegRateBias:   ad13_q        <= cfg_i.data;
        rtbk_pkg::RegGainRate:   k_rate_q      <= cfg_i.data;
        rtbk_pkg::RegGainTorque: k_torque_q    <= cfg_i.data;
        rtbk_pkg::RegGainBias:   k_bias_q      <= cfg_i.data;
        rtbk_pkg::RegInitBias:   reload_bias_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= in_i.operation;
      ctrl_q <= in_i.control;
      gyro_q <= in_i.gyro;
    end
  end

  always_comb begin
    err       = Mw'(gyro_q) - Mw'(rate_q);
    ets       = $signed({1'b0, decay_q});
    ets_m1    = ets - rtbk_pkg::OneQ24;
    one_m_ets = rtbk_pkg::OneQ24 - ets;

    acc_rate = (rtbk_pkg::widen(rate_q) <<< 8)
             + rtbk_pkg::mul_term(Mw'(torque_q), Mw'(ad12_q))
             + rtbk_pkg::mul_term(Mw'(bias_q), Mw'(ad13_q))
             - rtbk_pkg::mul_term(Mw'(ctrl_q), Mw'(ad13_q))
             + rtbk_pkg::mul_term(err, Mw'(k_rate_q));

    acc_torque = rtbk_pkg::mul_term(Mw'(torque_q), Mw'(ets))
               + rtbk_pkg::mul_term(Mw'(bias_q), Mw'(ets_m1))
               + rtbk_pkg::mul_term(Mw'(ctrl_q), Mw'(one_m_ets))
               + rtbk_pkg::mul_term(err, Mw'(k_torque_q));

    acc_bias = (rtbk_pkg::widen(bias_q) <<< 8)
             + rtbk_pkg::mul_term(err, Mw'(k_bias_q));

    if (op_q == rtbk_pkg::OpReinit) begin
      rate_d   = '0;
      torque_d = '0;
      bias_d   = reload_bias_q;
    end else begin
      rate_d   = rtbk_pkg::finish(acc_rate);
      torque_d = rtbk_pkg::finish(acc_torque);
      bias_d   = rtbk_pkg::finish(acc_bias);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= '0;
      torque_q <= '0;
      bias_q   <= '0;
    end else if (fire) begin
      rate_q   <= rate_d;
      torque_q <= torque_d;
      bias_q   <= bias_d;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.rate   = rate_q;
  assign out_o.torque = torque_q;
  assign out_o.bias   = bias_q;

`ifndef SYNTH
  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q)
    else $error("input stalled with empty input register");

  a_state_holds_without_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(rate_q) && $stable(torque_q) && $stable(bias_q))
    else $error("state changed without a processed word");

  a_reinit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && op_q == rtbk_pkg::OpReinit |=> rate_q == '0 && torque_q == '0)
    else $error("reinit left rate or torque nonzero");

  a_result_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire))
    else $error("result valid without a processed word");
`endif

endmodule

`default_nettype wire

### bench/rtbk_filter_checker.sv
// Checker for the rate/torque/bias filter: tracks register writes, predicts each state word and compares.
module rtbk_filter_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtbk_in_if         in_ch,
  rtbk_out_if        out_ch,
  rtbk_cfg_if        cfg_ch,
  output int         mismatch_cnt_o,
  output int         words_in_flight_o
);

  typedef struct packed {
    rtbk_pkg::data_t rate;
    rtbk_pkg::data_t torque;
    rtbk_pkg::data_t bias;
  } axis_state_t;

  logic [rtbk_pkg::DecayWidth-1:0] decay_q;
  rtbk_pkg::data_t                 rate_from_torque_q;
  rtbk_pkg::data_t                 rate_from_bias_q;
  rtbk_pkg::data_t                 gain_rate_q;
  rtbk_pkg::data_t                 gain_torque_q;
  rtbk_pkg::data_t                 gain_bias_q;
  rtbk_pkg::data_t                 initial_bias_q;

  rtbk_pkg::data_t rate_st;
  rtbk_pkg::data_t torque_st;
  rtbk_pkg::data_t bias_st;

  axis_state_t expected_states_q[$];
  axis_state_t want_word;
  int          mismatch_total;

  function automatic longint scale_q24(input longint val, input longint coef);
    return (val * coef) >>> 16;
  endfunction

  function automatic rtbk_pkg::data_t round_sat(input longint acc);
    longint r;
    r = (acc + 128) >>> 8;
    if (r > 64'sd2147483647) return rtbk_pkg::data_t'(32'h7fff_ffff);
    if (r < -64'sd2147483648) return rtbk_pkg::data_t'(32'h8000_0000);
    return rtbk_pkg::data_t'(r);
  endfunction

  function automatic axis_state_t advance_axis(input rtbk_pkg::op_e op,
                                               input rtbk_pkg::data_t ctrl,
                                               input rtbk_pkg::data_t gyro);
    longint w, u, b, c, err, ets, unity, acc;
    axis_state_t nxt;
    if (op == rtbk_pkg::OpReinit) begin
      rate_st = '0;
      torque_st = '0;
      bias_st = initial_bias_q;
    end else begin
      w = rate_st;
      u = torque_st;
      b = bias_st;
      c = ctrl;
      err = longint'(gyro) - w;
      ets = longint'(decay_q);
      unity = longint'(rtbk_pkg::OneQ24);
      acc = w * 256 + scale_q24(u, rate_from_torque_q) + scale_q24(b, rate_from_bias_q)
          - scale_q24(c, rate_from_bias_q) + scale_q24(err, gain_rate_q);
      rate_st = round_sat(acc);
      acc = scale_q24(u, ets) + scale_q24(b, ets - unity) + scale_q24(c, unity - ets)
          + scale_q24(err, gain_torque_q);
      torque_st = round_sat(acc);
      acc = b * 256 + scale_q24(err, gain_bias_q);
      bias_st = round_sat(acc);
    end
    nxt.rate = rate_st;
    nxt.torque = torque_st;
    nxt.bias = bias_st;
    return nxt;
  endfunction

  function automatic void check_field(input string field, input rtbk_pkg::data_t want,
                                      input rtbk_pkg::data_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q = rtbk_pkg::DecayWidth'(1 << 24);
      rate_from_torque_q = '0;
      rate_from_bias_q = '0;
      gain_rate_q = 32'sd736560;
      gain_torque_q = 32'sd3355;
      gain_bias_q = -32'sd1678;
      initial_bias_q = '0;
      rate_st = '0;
      torque_st = '0;
      bias_st = '0;
      expected_states_q.delete();
      mismatch_total = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (rtbk_pkg::cfg_reg_e'(cfg_ch.index))
          rtbk_pkg::RegDecay:      decay_q = cfg_ch.data[rtbk_pkg::DecayWidth-1:0];
          rtbk_pkg::RegRateTorque: rate_from_torque_q = cfg_ch.data;
          rtbk_pkg::RegRateBias:   rate_from_bias_q = cfg_ch.data;
          rtbk_pkg::RegGainRate:   gain_rate_q = cfg_ch.data;
          rtbk_pkg::RegGainTorque: gain_torque_q = cfg_ch.data;
          rtbk_pkg::RegGainBias:   gain_bias_q = cfg_ch.data;
          rtbk_pkg::RegInitBias:   initial_bias_q = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_states_q.size() == 0) begin
          $error("result word with no input word pending: rate %0d torque %0d bias %0d",
                 out_ch.rate, out_ch.torque, out_ch.bias);
          mismatch_total++;
        end else begin
          want_word = expected_states_q.pop_front();
          check_field("rate", want_word.rate, out_ch.rate);
          check_field("torque", want_word.torque, out_ch.torque);
          check_field("bias", want_word.bias, out_ch.bias);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_states_q.push_back(advance_axis(in_ch.operation, in_ch.control, in_ch.gyro));
      end
    end
    mismatch_cnt_o <= mismatch_total;
    words_in_flight_o <= expected_states_q.size();
  end

endmodule

### bench/rate_torque_bias_kalman_step_tb.sv
// Testbench top for the rate/torque/bias filter step: clock, reset, stimulus and verdict.
module rate_torque_bias_kalman_step_tb;

  localparam int CycleLimit = 500000;
  localparam logic [rtbk_pkg::CfgIdxWidth-1:0] RegOutOfRange = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_idle = 1'b0;
  int   mismatch_cnt;
  int   words_in_flight;
  int   cycle_cnt;

  rtbk_in_if  in_ch ();
  rtbk_out_if out_ch ();
  rtbk_cfg_if cfg_ch ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rate_torque_bias_kalman_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  rtbk_filter_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_ch            (cfg_ch),
    .mismatch_cnt_o    (mismatch_cnt),
    .words_in_flight_o (words_in_flight)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rtbk_pkg::data_t rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return rtbk_pkg::data_t'(32'h7fff_ffff);
          1: return rtbk_pkg::data_t'(32'h8000_0000);
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return rtbk_pkg::data_t'($urandom_range(0, 32'h3f_ffff))
                         - rtbk_pkg::data_t'(32'h20_0000);
      default: return rtbk_pkg::data_t'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1, 2: return 32'($urandom_range(0, 32'h1ff_ffff)) - 32'h100_0000;
      3: return 32'($urandom_range(0, 32'h1f_ffff)) - 32'h10_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_decay();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h1ff_ffff));
      default: return 32'($urandom_range(16000000, 16777216));
    endcase
  endfunction

  task automatic send_word(input rtbk_pkg::op_e op, input rtbk_pkg::data_t ctrl,
                           input rtbk_pkg::data_t gyro_v);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.control <= ctrl;
    in_ch.gyro <= gyro_v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (words_in_flight != 0);
  endtask

  task automatic write_reg(input logic [rtbk_pkg::CfgIdxWidth-1:0] idx,
                           input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] decay, input logic [31:0] a12,
                               input logic [31:0] a13, input logic [31:0] k_rate,
                               input logic [31:0] k_torque, input logic [31:0] k_bias,
                               input logic [31:0] reload_bias);
    write_reg(rtbk_pkg::RegDecay, decay);
    write_reg(rtbk_pkg::RegRateTorque, a12);
    write_reg(rtbk_pkg::RegRateBias, a13);
    write_reg(rtbk_pkg::RegGainRate, k_rate);
    write_reg(rtbk_pkg::RegGainTorque, k_torque);
    write_reg(rtbk_pkg::RegGainBias, k_bias);
    write_reg(rtbk_pkg::RegInitBias, reload_bias);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) == 0) settle();
      if ($urandom_range(0, 11) == 0) begin
        send_word(rtbk_pkg::OpReinit, rand_value(), rand_value());
      end else begin
        send_word(rtbk_pkg::OpStep, rand_value(), rand_value());
      end
    end
    settle();
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) stall = gap_len();
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.operation <= rtbk_pkg::OpStep;
    in_ch.control <= '0;
    in_ch.gyro <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= rtbk_pkg::RegDecay;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients
    send_word(rtbk_pkg::OpStep, '0, '0);
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h7fff_ffff),
              rtbk_pkg::data_t'(32'h7fff_ffff));
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h8000_0000),
              rtbk_pkg::data_t'(32'h8000_0000));
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h8000_0000),
              rtbk_pkg::data_t'(32'h7fff_ffff));
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h7fff_ffff),
              rtbk_pkg::data_t'(32'h8000_0000));
    send_word(rtbk_pkg::OpReinit, rtbk_pkg::data_t'(32'h1234_5678),
              rtbk_pkg::data_t'(32'h8765_4321));
    send_word(rtbk_pkg::OpStep, '1, rtbk_pkg::data_t'(32'sd1));
    send_word(rtbk_pkg::OpReinit, '0, '0);
    send_word(rtbk_pkg::OpReinit, '1, '1);
    run_random(100);

    // extremes, decay zero
    load_settings(32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(rtbk_pkg::OpReinit, '0, '0);
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h7fff_ffff),
              rtbk_pkg::data_t'(32'h8000_0000));
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h8000_0000),
              rtbk_pkg::data_t'(32'h7fff_ffff));
    send_word(rtbk_pkg::OpStep, '0, '0);
    send_word(rtbk_pkg::OpStep, '1, '1);
    run_random(80);

    // extremes, decay at full range with upper data bits set
    load_settings(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_word(rtbk_pkg::OpReinit, '0, '0);
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h7fff_ffff),
              rtbk_pkg::data_t'(32'h7fff_ffff));
    send_word(rtbk_pkg::OpStep, rtbk_pkg::data_t'(32'h8000_0000),
              rtbk_pkg::data_t'(32'h8000_0000));
    run_random(80);

    // plausible flight values
    load_settings(32'd16609444, 32'd838861, -32'sd167772, 32'd736560,
                  32'd3355, -32'sd1678, 32'd6554);
    write_reg(RegOutOfRange, $urandom());
    cfg_ch.valid <= 1'b0;
    run_random(150);

    for (int p = 0; p < 3; p++) begin
      load_settings(rand_decay(), rand_coef(), rand_coef(), rand_coef(),
                    rand_coef(), rand_coef(), $urandom());
      run_random(100);
    end

    settle();
    repeat (6) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
